// ===== rtl/regular_polygon_vertices_unit_assert.svh =====
// assertion macros for the polygon vertex unit
`ifndef REGULAR_POLYGON_VERTICES_UNIT_ASSERT_SVH
`define REGULAR_POLYGON_VERTICES_UNIT_ASSERT_SVH

// same-cycle implication
`define RPV_ASSERT_IMP(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("rpv assertion failed");

// next-cycle implication
`define RPV_ASSERT_NXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("rpv assertion failed");

`endif

// ===== rtl/rpv_pkg.sv =====
// package: constants, types and the arctangent table of the polygon vertex unit
package rpv_pkg;

	localparam int MAX_SIDES_DEF = 10;
	localparam int ANGLE_BITS_DEF = 16;
	localparam int CORDIC_ITERS = 16;
	localparam int FRAC_BITS = 16;
	localparam logic [31:0] GAIN_INV = 32'd39797;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ATAN,
		S_ANG,
		S_DIV,
		S_ADV,
		S_ROT,
		S_MUL,
		S_PLC,
		S_OUT
	} rpv_state_t;

	typedef struct packed {
		logic       load;
		logic       atan_step;
		logic       ang_take;
		logic       div_step;
		logic       rot_load;
		logic       rot_step;
		logic       mul;
		logic       out_take;
		logic [3:0] iter;
	} rpv_cmd_t;

	typedef struct packed {
		logic sides_zero;
		logic last;
	} rpv_sts_t;

	function automatic logic [31:0] atan_turn(input logic [3:0] i);
		logic [31:0] r;
		unique case (i)
			4'd0:    r = 32'd536870912;
			4'd1:    r = 32'd316933406;
			4'd2:    r = 32'd167458907;
			4'd3:    r = 32'd85004756;
			4'd4:    r = 32'd42667331;
			4'd5:    r = 32'd21354465;
			4'd6:    r = 32'd10679838;
			4'd7:    r = 32'd5340245;
			4'd8:    r = 32'd2670163;
			4'd9:    r = 32'd1335087;
			4'd10:   r = 32'd667544;
			4'd11:   r = 32'd333772;
			4'd12:   r = 32'd166886;
			4'd13:   r = 32'd83443;
			4'd14:   r = 32'd41722;
			default: r = 32'd20861;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/rpv_ctrl.sv =====
// controller state machine of the polygon vertex unit
module rpv_ctrl import rpv_pkg::*; #(
	parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  rpv_sts_t sts,
	output rpv_cmd_t cmd
);

	localparam int IW = $clog2(ANGLE_BITS + 1);
	localparam logic [IW-1:0] CORDIC_LAST = IW'(CORDIC_ITERS - 1);
	localparam logic [IW-1:0] DIV_LAST = IW'(ANGLE_BITS);

	rpv_state_t state_q, state_d;
	logic [IW-1:0] cnt_q;
	logic cnt_clr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (cnt_clr) cnt_q <= '0;
			else cnt_q <= cnt_q + IW'(1);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_ATAN;
			S_ATAN: if (cnt_q == CORDIC_LAST) state_d = S_ANG;
			S_ANG:  state_d = sts.sides_zero ? S_IDLE : S_DIV;
			S_DIV:  if (cnt_q == DIV_LAST) state_d = S_ADV;
			S_ADV:  state_d = S_ROT;
			S_ROT:  if (cnt_q == CORDIC_LAST) state_d = S_MUL;
			S_MUL:  state_d = S_PLC;
			S_PLC:  state_d = S_OUT;
			S_OUT:  if (out_ready) state_d = sts.last ? S_IDLE : S_ADV;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.iter = cnt_q[3:0];
		cnt_clr = 1'b1;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_ATAN: begin
				cmd.atan_step = 1'b1;
				cnt_clr = (cnt_q == CORDIC_LAST);
			end
			S_ANG: cmd.ang_take = 1'b1;
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_clr = (cnt_q == DIV_LAST);
			end
			S_ADV: cmd.rot_load = 1'b1;
			S_ROT: begin
				cmd.rot_step = 1'b1;
				cnt_clr = (cnt_q == CORDIC_LAST);
			end
			S_MUL: cmd.mul = 1'b1;
			S_OUT: begin
				out_valid = 1'b1;
				cmd.out_take = out_ready;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// ===== rtl/rpv_dp.sv =====
// datapath of the polygon vertex unit: divider, shared cordic, placement
module rpv_dp import rpv_pkg::*; #(
	parameter int MAX_SIDES = MAX_SIDES_DEF,
	parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [9:0]          center_x,
	input  logic [9:0]          center_y,
	input  logic [3:0]          sides,
	input  logic [5:0]          radius,
	input  rpv_cmd_t            cmd,
	output rpv_sts_t            sts,
	output logic [3:0]          vertex_index,
	output logic signed [10:0]  vertex_x,
	output logic signed [10:0]  vertex_y,
	output logic                last
);

	localparam int SH = 32 - ANGLE_BITS;

	function automatic logic signed [10:0] place(input logic [9:0] c,
			input logic signed [38:0] p);
		logic signed [39:0] v;
		logic [39:0] mag;
		logic [39:0] rm;
		logic neg;
		logic signed [10:0] r;
		v = $signed({14'd0, c, 16'd0}) + 40'(p);
		neg = v[39];
		mag = neg ? 40'(-v) : 40'(v);
		rm = (mag + 40'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		if (!neg && rm > 40'd1023) r = 11'sd1023;
		else if (neg && rm > 40'd1024) r = -11'sd1024;
		else if (neg) r = 11'(-$signed(rm[11:0]));
		else r = 11'(rm);
		return r;
	endfunction

	logic [9:0] cx_q, cy_q;
	logic [3:0] sides_q, count_q, vidx_q;
	logic [5:0] rad_q;
	logic origin_q;
	logic [ANGLE_BITS-1:0] acc_q;
	logic [ANGLE_BITS:0] quo_q;
	logic [3:0] rem_q;
	logic signed [31:0] x_q, y_q;
	logic signed [33:0] z_q;
	logic vec_q;
	logic [1:0] quad_q;
	logic signed [38:0] px_q, py_q;
	logic [10:0] ox_q, oy_q;
	logic last_q;

	logic signed [31:0] dx, dy, tx, ty;
	logic signed [33:0] da;
	logic plus;
	logic [4:0] trial;
	logic fits;
	logic [ANGLE_BITS-1:0] nacc;
	logic [31:0] a32;
	logic [32:0] zr;
	logic [3:0] cnt_in;

	assign dx = y_q >>> cmd.iter;
	assign dy = x_q >>> cmd.iter;
	assign da = $signed({2'b00, atan_turn(cmd.iter)});
	assign plus = vec_q ? !(y_q > 32'sd0) : !z_q[33];
	assign trial = {rem_q, quo_q[ANGLE_BITS]};
	assign fits = trial >= {1'b0, sides_q};
	assign nacc = acc_q + quo_q[ANGLE_BITS-1:0];
	assign a32 = 32'(nacc) << SH;
	assign zr = {1'b0, z_q[31:0]} + 33'(64'd1 << (SH - 1));
	assign cnt_in = (int'(sides) > MAX_SIDES) ? 4'(MAX_SIDES) : sides;

	always_comb begin
		case (quad_q)
			2'd0: begin tx = x_q; ty = y_q; end
			2'd1: begin tx = -y_q; ty = x_q; end
			2'd2: begin tx = -x_q; ty = -y_q; end
			default: begin tx = y_q; ty = -x_q; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vidx_q <= '0;
			count_q <= '0;
			sides_q <= '0;
			vec_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				vidx_q <= '0;
				count_q <= cnt_in;
				sides_q <= sides;
				vec_q <= 1'b1;
			end else if (cmd.rot_load) begin
				vec_q <= 1'b0;
			end
			if (cmd.out_take) vidx_q <= vidx_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q <= center_x;
			cy_q <= center_y;
			rad_q <= radius;
			origin_q <= (center_x == 10'd0) && (center_y == 10'd0);
			x_q <= $signed({6'd0, center_x, 16'd0});
			y_q <= $signed({6'd0, center_y, 16'd0});
			z_q <= '0;
			quo_q <= (ANGLE_BITS+1)'(1 << ANGLE_BITS) + (ANGLE_BITS+1)'(sides >> 1);
			rem_q <= '0;
		end
		if (cmd.atan_step || cmd.rot_step) begin
			if (plus) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - da;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + da;
			end
		end
		if (cmd.ang_take) acc_q <= origin_q ? '0 : zr[31:SH];
		if (cmd.div_step) begin
			rem_q <= fits ? 4'(trial - {1'b0, sides_q}) : trial[3:0];
			quo_q <= {quo_q[ANGLE_BITS-1:0], fits};
		end
		if (cmd.rot_load) begin
			acc_q <= nacc;
			quad_q <= a32[31:30];
			x_q <= $signed(GAIN_INV);
			y_q <= '0;
			z_q <= $signed({4'd0, a32[29:0]});
		end
		if (cmd.mul) begin
			px_q <= 39'(tx) * 39'($signed({1'b0, rad_q}));
			py_q <= 39'(ty) * 39'($signed({1'b0, rad_q}));
			last_q <= (vidx_q + 4'd1) == count_q;
		end
	end

	always_ff @(posedge clk) begin
		ox_q <= place(cx_q, px_q);
		oy_q <= place(cy_q, py_q);
	end

	assign sts.sides_zero = (sides_q == 4'd0);
	assign sts.last = last_q;
	assign vertex_index = vidx_q;
	assign vertex_x = $signed(ox_q);
	assign vertex_y = $signed(oy_q);
	assign last = last_q;

endmodule

// ===== rtl/regular_polygon_vertices_unit.sv =====
// the start angle comes from a vectoring pass of the cordic, then a bit-serial divide gives the step angle,
// then each vertex takes an advance, 16 cordic rotations, a multiply, a round and an output step
// a new item is taken only when idle
// throughput is set by the single shared cordic iterating one step a cycle
// arst_n clears the controller to idle and the vertex counters
module regular_polygon_vertices_unit import rpv_pkg::*; #(
	parameter int MAX_SIDES = MAX_SIDES_DEF,
	parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [9:0]         center_x,
	input  logic [9:0]         center_y,
	input  logic [3:0]         sides,
	input  logic [5:0]         radius,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [3:0]         vertex_index,
	output logic signed [10:0] vertex_x,
	output logic signed [10:0] vertex_y,
	output logic               last
);

	`include "regular_polygon_vertices_unit_assert.svh"

	rpv_cmd_t cmd;
	rpv_sts_t sts;

	rpv_ctrl #(
		.ANGLE_BITS(ANGLE_BITS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts(sts),
		.cmd(cmd)
	);

	rpv_dp #(
		.MAX_SIDES(MAX_SIDES),
		.ANGLE_BITS(ANGLE_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.center_x(center_x),
		.center_y(center_y),
		.sides(sides),
		.radius(radius),
		.cmd(cmd),
		.sts(sts),
		.vertex_index(vertex_index),
		.vertex_x(vertex_x),
		.vertex_y(vertex_y),
		.last(last)
	);

	`RPV_ASSERT_IMP(a_no_overlap, out_valid, !in_ready)
	`RPV_ASSERT_NXT(a_last_to_idle, out_valid && out_ready && last, in_ready)
	`RPV_ASSERT_NXT(a_take_busy, in_valid && in_ready, !in_ready && !out_valid)

endmodule

// ===== sim/tb.sv =====
// testbench for the regular polygon vertex unit: self-checking with random stimulus and stalls
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rpv_pkg::*;

	typedef struct packed {
		logic [3:0]         idx;
		logic signed [10:0] vx;
		logic signed [10:0] vy;
		logic               lst;
	} vertex_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [9:0]         center_x = '0;
	logic [9:0]         center_y = '0;
	logic [3:0]         sides = '0;
	logic [5:0]         radius = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [3:0]         vertex_index;
	logic signed [10:0] vertex_x;
	logic signed [10:0] vertex_y;
	logic               last;

	vertex_t     vertex_queue[$];
	int          mismatches = 0;
	int          vertices_seen = 0;
	int          polygons_sent = 0;
	int          cycle_count = 0;
	int          burst_left = 0;
	int          stall_mode = 0;
	bit          gaps_on = 1'b1;
	logic [63:0] atan_lut[16];

	regular_polygon_vertices_unit uut (.*);

	always #4 clk = ~clk;

	initial begin
		atan_lut = '{64'd536870912, 64'd316933406, 64'd167458907, 64'd85004756,
			64'd42667331, 64'd21354465, 64'd10679838, 64'd5340245, 64'd2670163,
			64'd1335087, 64'd667544, 64'd333772, 64'd166886, 64'd83443,
			64'd41722, 64'd20861};
	end

	function automatic longint asr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic logic [15:0] start_angle(logic [9:0] cx, logic [9:0] cy);
		longint x, y, z, dx, dy;
		logic [31:0] zr;
		logic [32:0] t;
		x = longint'(cx) <<< 16;
		y = longint'(cy) <<< 16;
		z = 0;
		if (cx == 0 && cy == 0)
			return '0;
		for (int i = 0; i < 16; i++) begin
			dx = asr(y, i);
			dy = asr(x, i);
			if (y > 0) begin
				x += dx; y -= dy; z += longint'(atan_lut[i]);
			end else begin
				x -= dx; y += dy; z -= longint'(atan_lut[i]);
			end
		end
		zr = z[31:0];
		t = {1'b0, zr} + 33'd32768;
		return t[31:16];
	endfunction

	function automatic logic signed [10:0] place_coord(logic [9:0] c, logic [5:0] r, longint trig);
		longint v, q;
		v = (longint'(c) <<< 16) + longint'(r) * trig;
		if (v >= 0)
			q = (v + 32768) >>> 16;
		else
			q = -((-v + 32768) >>> 16);
		if (q > 1023) q = 1023;
		if (q < -1024) q = -1024;
		return q[10:0];
	endfunction

	task automatic predict_vertices(logic [9:0] cx, logic [9:0] cy, logic [3:0] n, logic [5:0] r);
		logic [15:0] acc, stp;
		logic [31:0] a32;
		longint x, y, z, dx, dy, c, s;
		int count;
		vertex_t v;
		acc = start_angle(cx, cy);
		if (n == 0)
			return;
		stp = 16'((32'd65536 + 32'(n / 2)) / 32'(n));
		count = (n > MAX_SIDES_DEF) ? MAX_SIDES_DEF : n;
		for (int k = 0; k < count; k++) begin
			acc = acc + stp;
			a32 = {acc, 16'h0};
			z = longint'(a32[29:0]);
			x = 39797;
			y = 0;
			for (int i = 0; i < 16; i++) begin
				dx = asr(y, i);
				dy = asr(x, i);
				if (z >= 0) begin
					x -= dx; y += dy; z -= longint'(atan_lut[i]);
				end else begin
					x += dx; y -= dy; z += longint'(atan_lut[i]);
				end
			end
			case (a32[31:30])
				2'd0: begin c = x; s = y; end
				2'd1: begin c = -y; s = x; end
				2'd2: begin c = -x; s = -y; end
				default: begin c = y; s = -x; end
			endcase
			v.idx = 4'(k);
			v.vx = place_coord(cx, r, c);
			v.vy = place_coord(cy, r, s);
			v.lst = (k + 1 == count);
			vertex_queue.push_back(v);
		end
	endtask

	task automatic send_polygon(logic [9:0] cx, logic [9:0] cy, logic [3:0] n, logic [5:0] r);
		if (gaps_on) begin
			if (burst_left == 0) begin
				repeat ($urandom_range(0, 40)) @(posedge clk);
				burst_left = $urandom_range(1, 6);
			end
			burst_left--;
		end
		in_valid <= 1'b1;
		center_x <= cx;
		center_y <= cy;
		sides <= n;
		radius <= r;
		do @(posedge clk); while (!in_ready);
		predict_vertices(cx, cy, n, r);
		polygons_sent++;
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain_wait();
		while (vertex_queue.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic test_corners();
		send_polygon(10'd0, 10'd0, 4'd4, 6'd30);
		send_polygon(10'd799, 10'd599, 4'd10, 6'd59);
		send_polygon(10'd1023, 10'd1023, 4'd15, 6'd63);
		send_polygon(10'd0, 10'd599, 4'd1, 6'd0);
		send_polygon(10'd799, 10'd0, 4'd3, 6'd45);
		send_polygon(10'd400, 10'd300, 4'd0, 6'd40);
		send_polygon(10'd5, 10'd5, 4'd6, 6'd63);
		send_polygon(10'd1020, 10'd3, 4'd11, 6'd63);
		send_polygon(10'd0, 10'd1023, 4'd8, 6'd63);
		send_polygon(10'd1, 10'd0, 4'd2, 6'd31);
		send_polygon(10'd0, 10'd1, 4'd5, 6'd1);
		send_polygon(10'd512, 10'd512, 4'd12, 6'd32);
	endtask

	task automatic test_random(int count);
		logic [3:0] n;
		for (int i = 0; i < count; i++) begin
			n = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(1, 10));
			if ($urandom_range(0, 7) == 0)
				send_polygon(10'($urandom), 10'($urandom), n, 6'($urandom));
			else
				send_polygon(10'($urandom_range(0, 799)), 10'($urandom_range(0, 599)), n,
					6'($urandom_range(30, 59)));
			if (i == count / 2)
				drain_wait();
		end
	endtask

	task automatic test_back_to_back(int count);
		gaps_on = 1'b0;
		stall_mode = 2;
		test_random(count);
		gaps_on = 1'b1;
		stall_mode = 0;
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		case (stall_mode)
			1: out_ready <= ($urandom_range(0, 3) == 0);
			2: out_ready <= 1'b1;
			default: out_ready <= (($urandom_range(0, 15) != 0) && (cycle_count % 23 > 3));
		endcase
	end

	always @(posedge clk) begin
		vertex_t e;
		if (arst_n && out_valid && out_ready) begin
			vertices_seen++;
			if (vertex_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer: idx %0d x %0d y %0d last %0b",
						vertex_index, vertex_x, vertex_y, last);
			end else begin
				e = vertex_queue.pop_front();
				if (e.idx !== vertex_index || e.vx !== vertex_x || e.vy !== vertex_y
						|| e.lst !== last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp idx %0d x %0d y %0d last %0b, got %0d %0d %0d %0b",
							e.idx, e.vx, e.vy, e.lst, vertex_index, vertex_x, vertex_y, last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycle_count > 900000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corners();
		stall_mode = 1;
		test_random(150);
		stall_mode = 0;
		test_random(150);
		test_back_to_back(70);
		drain_wait();
		if (vertex_queue.size() != 0)
			mismatches++;
		$display("covered %0d polygons, %0d vertices checked, with gaps and output stalls",
			polygons_sent, vertices_seen);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
